// File: rtl/core/scf_pkg.sv
// Shared types and constants for the scanline clamped fetch block.
// Holds the request and response transaction structs and the controller/datapath interface.
// No dependencies.
package scf_pkg;

   localparam int STORE_DEPTH   = 16384;
   localparam int STORE_AW      = 14;
   localparam int MAX_WIDTH_DEF = 4096;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 13;
   localparam int SPP_W         = 3;
   localparam int IMG_W_W       = 13;
   localparam int SLOT_W        = 2;
   localparam int SLOTS         = 4;

   localparam logic [SPP_W-1:0]   SPP_RESET   = 3'd4;
   localparam logic [IMG_W_W-1:0] WIDTH_RESET = 13'd4096;

   localparam logic                 CMD_LOAD  = 1'b0;
   localparam logic                 CMD_FETCH = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPP   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH = 1'b1;

   typedef struct packed {
      logic               command;
      logic [13:0]        byte_index;
      logic [7:0]         byte_value;
      logic signed [15:0] column;
   } req_type;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   typedef struct packed {
      logic              load_we;
      logic              fetch_capture;
      logic              calc_base;
      logic              issue;
      logic              format;
      logic [SLOT_W-1:0] slot;
   } cmd_type;

   typedef struct packed {
      logic last_slot;
   } status_type;

endpackage

// File: rtl/core/scf_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module scf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/scf_ctrl.sv
// Controller state machine: accepts transactions and sequences the datapath.
// Depends on scf_pkg.
module scf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               command,
   input  scf_pkg::status_type status,
   output scf_pkg::cmd_type    cmd,
   output logic               busy,
   output logic               rsp_valid
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BASE,
      ST_ISSUE,
      ST_WAIT,
      ST_FORMAT
   } state_type;

   state_type                       state_ff;
   logic [scf_pkg::SLOT_W-1:0]      slot_ff;
   logic                            rsp_valid_ff;
   logic                            accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      cmd               = '0;
      cmd.load_we       = accept && (command == scf_pkg::CMD_LOAD);
      cmd.fetch_capture = accept && (command == scf_pkg::CMD_FETCH);
      cmd.calc_base     = (state_ff == ST_BASE);
      cmd.issue         = (state_ff == ST_ISSUE);
      cmd.format        = (state_ff == ST_FORMAT);
      cmd.slot          = slot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               slot_ff <= '0;
               if (accept && (command == scf_pkg::CMD_FETCH)) begin
                  state_ff <= ST_BASE;
               end
            end
            ST_BASE: begin
               state_ff <= ST_ISSUE;
            end
            ST_ISSUE: begin
               slot_ff <= slot_ff + 1'b1;
               if (status.last_slot) begin
                  state_ff <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               state_ff <= ST_FORMAT;
            end
            ST_FORMAT: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_fetch_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && command == scf_pkg::CMD_FETCH) |=> busy)
      else $error("fetch accepted without going busy");

   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && command == scf_pkg::CMD_LOAD) |=> !busy)
      else $error("load left the controller busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held longer than one cycle");

   a_strobe_after_format: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == ST_FORMAT && !busy))
      else $error("response strobe outside its slot");

endmodule

// File: rtl/core/scf_dpath.sv
// Datapath: configuration registers, column clamp, address generation, row store, pixel format.
// Depends on scf_pkg and scf_ram.
module scf_dpath #(
   parameter int MAX_WIDTH = scf_pkg::MAX_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  scf_pkg::cmd_type                  cmd,
   output scf_pkg::status_type               status,
   input  scf_pkg::req_type                  req,
   input  logic                              csr_we,
   input  logic [scf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [scf_pkg::CSR_DATA_W-1:0]    csr_data,
   output scf_pkg::rsp_type                  rsp
);

   localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int BASE_W = COL_W + scf_pkg::SPP_W;
   localparam int AW     = scf_pkg::STORE_AW;
   localparam int SUM_W  = (BASE_W > AW) ? BASE_W : AW;

   logic [scf_pkg::SPP_W-1:0]   spp_ff;
   logic [scf_pkg::IMG_W_W-1:0] width_ff;
   logic [COL_W-1:0]            col_ff;
   logic [scf_pkg::SPP_W-1:0]   spp_eff_ff;
   logic [BASE_W-1:0]           base_ff;
   logic                        rd_valid_ff;
   logic [scf_pkg::SLOT_W-1:0]  rd_slot_ff;
   logic [7:0]                  bytes_ff [scf_pkg::SLOTS];
   scf_pkg::rsp_type            rsp_ff;

   logic [15:0]               width_eff;
   logic [15:0]               limit;
   logic [15:0]               col_clamped;
   logic [scf_pkg::SPP_W-1:0] spp_eff_in;
   logic [SUM_W-1:0]          addr_sum;
   logic [AW-1:0]             rd_addr;
   logic [7:0]                rd_data;
   scf_pkg::rsp_type          rsp_in;

   always_comb begin
      width_eff = 16'(width_ff);
      if (width_eff == 16'd0) begin
         width_eff = 16'd1;
      end
      if (width_eff > 16'(MAX_WIDTH)) begin
         width_eff = 16'(MAX_WIDTH);
      end
      limit = width_eff - 16'd1;
      if (req.column[15]) begin
         col_clamped = 16'd0;
      end else if ($unsigned(req.column) > limit) begin
         col_clamped = limit;
      end else begin
         col_clamped = $unsigned(req.column);
      end
   end

   always_comb begin
      spp_eff_in = spp_ff;
      if (spp_ff == 3'd0) begin
         spp_eff_in = 3'd1;
      end else if (spp_ff > 3'd4) begin
         spp_eff_in = 3'd4;
      end
   end

   assign addr_sum = SUM_W'(base_ff) + SUM_W'(cmd.slot);
   assign rd_addr  = addr_sum[AW-1:0];
   assign status.last_slot = ((scf_pkg::SPP_W'(cmd.slot) + 3'd1) == spp_eff_ff);

   always_comb begin
      rsp_in = '0;
      case (spp_eff_ff)
         3'd1: begin
            rsp_in.red   = bytes_ff[0];
            rsp_in.green = bytes_ff[0];
            rsp_in.blue  = bytes_ff[0];
            rsp_in.alpha = bytes_ff[0];
         end
         3'd2: begin
            rsp_in.red   = bytes_ff[0];
            rsp_in.green = bytes_ff[0];
            rsp_in.blue  = bytes_ff[0];
            rsp_in.alpha = bytes_ff[1];
         end
         3'd3: begin
            rsp_in.red   = bytes_ff[0];
            rsp_in.green = bytes_ff[1];
            rsp_in.blue  = bytes_ff[2];
            rsp_in.alpha = 8'hff;
         end
         default: begin
            rsp_in.red   = bytes_ff[0];
            rsp_in.green = bytes_ff[1];
            rsp_in.blue  = bytes_ff[2];
            rsp_in.alpha = bytes_ff[3];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spp_ff      <= scf_pkg::SPP_RESET;
         width_ff    <= scf_pkg::WIDTH_RESET;
         rd_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               scf_pkg::CSR_SPP:   spp_ff   <= csr_data[scf_pkg::SPP_W-1:0];
               scf_pkg::CSR_WIDTH: width_ff <= csr_data[scf_pkg::IMG_W_W-1:0];
               default: begin
               end
            endcase
         end
         rd_valid_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch_capture) begin
         col_ff     <= COL_W'(col_clamped);
         spp_eff_ff <= spp_eff_in;
      end
      if (cmd.calc_base) begin
         base_ff <= BASE_W'(col_ff) * BASE_W'(spp_eff_ff);
      end
      rd_slot_ff <= cmd.slot;
      if (rd_valid_ff) begin
         bytes_ff[rd_slot_ff] <= rd_data;
      end
      if (cmd.format) begin
         rsp_ff <= rsp_in;
      end
   end

   scf_ram #(
      .WIDTH (8),
      .DEPTH (scf_pkg::STORE_DEPTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (cmd.load_we),
      .wr_addr (req.byte_index),
      .wr_data (req.byte_value),
      .rd_en   (cmd.issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp = rsp_ff;

endmodule

// File: rtl/core/scanline_clamped_fetch_to_argb_top.sv
// Scanline clamped fetch to ARGB8888: a one-row sample store with edge-clamped pixel fetch.
// Depends on scf_pkg, scf_ctrl, scf_dpath and scf_ram.
//
// Request channel: a transaction is taken when start is high and busy is low.
// A load (command 0) writes byte_value at byte_index in the row store in that
// same cycle and busy stays low, so loads go at one per cycle.
// A fetch (command 1) clamps column to 0 .. W-1, W being image_width held to 1..MAX_WIDTH,
// then reads the pixel's N samples (N = effective sample count, 1..4) one per cycle
// from the single read port of the row store. busy is high until the result is out.
// The controller passes through its base, issue, wait and format states; rsp_valid
// then rises and lasts one cycle with the pixel on rsp_payload, and start is taken again
// in that same cycle. The receiver cannot stall; rsp_payload is held until the next
// fetch completes.
// Configuration: csr_ready is always high; write only while busy is low.
// Reset: the sample count returns to 4 and image_width to 4096; the row store
// is not cleared and must be written before it is read.
module scanline_clamped_fetch_to_argb_top #(
   parameter int MAX_WIDTH = scf_pkg::MAX_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  scf_pkg::req_type               req_payload,
   output logic                           rsp_valid,
   output scf_pkg::rsp_type               rsp_payload,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [scf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [scf_pkg::CSR_DATA_W-1:0] csr_data
);

   scf_pkg::cmd_type    cmd;
   scf_pkg::status_type status;

   assign csr_ready = 1'b1;

   scf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .command   (req_payload.command),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   scf_dpath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req       (req_payload),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp       (rsp_payload)
   );

endmodule

// File: tb/tb_scanline_clamped_fetch_to_argb_top.sv
// Testbench for scanline_clamped_fetch_to_argb_top: directed table, then random load/fetch traffic.
// Pixels are predicted from a shadow row store and shadow registers; depends on scf_pkg.
// Every fetch reads only bytes already loaded; results are checked field by field in order.
module tb_scanline_clamped_fetch_to_argb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT    = 2000;
   localparam int DIRECTED_ROWS = 31;
   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 80;

   typedef enum logic [1:0] {STEP_LOAD, STEP_FETCH, STEP_SPP, STEP_WIDTH} step_kind_type;

   typedef struct packed {
      step_kind_type      kind;
      logic [13:0]        idx;
      logic [12:0]        data;
      logic signed [15:0] col;
      logic               typed;
      scf_pkg::rsp_type   pix;
   } step_row_type;

   logic                           clock       = 1'b0;
   logic                           reset       = 1'b1;
   logic                           start       = 1'b0;
   logic                           busy;
   scf_pkg::req_type               req_payload = '0;
   logic                           rsp_valid;
   scf_pkg::rsp_type               rsp_payload;
   logic                           csr_valid   = 1'b0;
   logic                           csr_ready;
   logic [scf_pkg::CSR_IDX_W-1:0]  csr_index   = scf_pkg::CSR_SPP;
   logic [scf_pkg::CSR_DATA_W-1:0] csr_data    = '0;

   logic [7:0]       row_copy    [scf_pkg::STORE_DEPTH];
   bit               row_written [scf_pkg::STORE_DEPTH];
   logic [2:0]       spp_reg   = scf_pkg::SPP_RESET;
   logic [12:0]      width_reg = scf_pkg::WIDTH_RESET;
   scf_pkg::rsp_type pending_pixels [$];
   int               mismatches = 0;
   int               items_sent = 0;
   int               burst_left = 0;
   int               idle_cycles = 0;

   step_row_type directed_steps [DIRECTED_ROWS] = '{
      '{STEP_LOAD,  14'd0,     13'h11,   16'sd0,     1'b0, 32'h0},
      '{STEP_LOAD,  14'd1,     13'h22,   16'sd0,     1'b0, 32'h0},
      '{STEP_LOAD,  14'd2,     13'h33,   16'sd0,     1'b0, 32'h0},
      '{STEP_LOAD,  14'd3,     13'h44,   16'sd0,     1'b0, 32'h0},
      '{STEP_FETCH, 14'd0,     13'h0,    16'sd0,     1'b1, 32'h44112233},
      '{STEP_FETCH, 14'd0,     13'h0,    16'sh8000,  1'b1, 32'h44112233},
      '{STEP_LOAD,  14'd16380, 13'h00,   16'sd0,     1'b0, 32'h0},
      '{STEP_LOAD,  14'd16381, 13'hff,   16'sd0,     1'b0, 32'h0},
      '{STEP_LOAD,  14'd16382, 13'h80,   16'sd0,     1'b0, 32'h0},
      '{STEP_LOAD,  14'd16383, 13'h7f,   16'sd0,     1'b0, 32'h0},
      '{STEP_FETCH, 14'd0,     13'h0,    16'sd4095,  1'b1, 32'h7f00ff80},
      '{STEP_FETCH, 14'd0,     13'h0,    16'sh7fff,  1'b1, 32'h7f00ff80},
      '{STEP_SPP,   14'd0,     13'd3,    16'sd0,     1'b0, 32'h0},
      '{STEP_FETCH, 14'd0,     13'h0,    16'sd0,     1'b1, 32'hff112233},
      '{STEP_SPP,   14'd0,     13'd2,    16'sd0,     1'b0, 32'h0},
      '{STEP_FETCH, 14'd0,     13'h0,    16'sd1,     1'b1, 32'h44333333},
      '{STEP_SPP,   14'd0,     13'd1,    16'sd0,     1'b0, 32'h0},
      '{STEP_FETCH, 14'd0,     13'h0,    16'sd3,     1'b1, 32'h44444444},
      '{STEP_FETCH, 14'd0,     13'h0,    -16'sd1,    1'b1, 32'h11111111},
      '{STEP_SPP,   14'd0,     13'd0,    16'sd0,     1'b0, 32'h0},
      '{STEP_FETCH, 14'd0,     13'h0,    16'sd2,     1'b1, 32'h33333333},
      '{STEP_SPP,   14'd0,     13'd7,    16'sd0,     1'b0, 32'h0},
      '{STEP_FETCH, 14'd0,     13'h0,    16'sd0,     1'b1, 32'h44112233},
      '{STEP_WIDTH, 14'd0,     13'd0,    16'sd0,     1'b0, 32'h0},
      '{STEP_FETCH, 14'd0,     13'h0,    16'sh7fff,  1'b1, 32'h44112233},
      '{STEP_WIDTH, 14'd0,     13'h1fff, 16'sd0,     1'b0, 32'h0},
      '{STEP_FETCH, 14'd0,     13'h0,    16'sd5000,  1'b1, 32'h7f00ff80},
      '{STEP_SPP,   14'd0,     13'd1,    16'sd0,     1'b0, 32'h0},
      '{STEP_WIDTH, 14'd0,     13'd2,    16'sd0,     1'b0, 32'h0},
      '{STEP_FETCH, 14'd0,     13'h0,    16'sd100,   1'b1, 32'h22222222},
      '{STEP_FETCH, 14'd0,     13'h0,    16'sd1,     1'b0, 32'h0}
   };

   scanline_clamped_fetch_to_argb_top uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #6 clock = ~clock;

   function automatic int eff_width();
      int w;
      w = int'(width_reg);
      if (w == 0) w = 1;
      if (w > scf_pkg::MAX_WIDTH_DEF) w = scf_pkg::MAX_WIDTH_DEF;
      return w;
   endfunction

   function automatic int eff_spp();
      int n;
      n = int'(spp_reg);
      if (n == 0) n = 1;
      if (n > 4) n = 4;
      return n;
   endfunction

   function automatic int clamp_column(input logic signed [15:0] col);
      int w;
      w = eff_width();
      if (col < 0) return 0;
      if (int'(col) > w - 1) return w - 1;
      return int'(col);
   endfunction

   function automatic scf_pkg::rsp_type argb_of_column(input logic signed [15:0] col);
      int               base;
      scf_pkg::rsp_type pix;
      base = clamp_column(col) * eff_spp();
      case (eff_spp())
         1: pix = {4{row_copy[base]}};
         2: pix = {row_copy[base + 1], {3{row_copy[base]}}};
         3: pix = {8'hff, row_copy[base], row_copy[base + 1], row_copy[base + 2]};
         default: pix = {row_copy[base + 3], row_copy[base], row_copy[base + 1],
                         row_copy[base + 2]};
      endcase
      return pix;
   endfunction

   function automatic scf_pkg::req_type make_req(input logic cmd, input logic [13:0] idx,
                                                 input logic [7:0] val,
                                                 input logic signed [15:0] col);
      scf_pkg::req_type t;
      t.command    = cmd;
      t.byte_index = idx;
      t.byte_value = val;
      t.column     = col;
      return t;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   task automatic send_txn(input scf_pkg::req_type t, input logic typed,
                           input scf_pkg::rsp_type typed_pix);
      start       <= 1'b1;
      req_payload <= t;
      do @(posedge clock); while (busy !== 1'b0);
      items_sent++;
      if (t.command == scf_pkg::CMD_LOAD) begin
         row_copy[t.byte_index]    = t.byte_value;
         row_written[t.byte_index] = 1'b1;
      end else begin
         pending_pixels.push_back(typed ? typed_pix : argb_of_column(t.column));
      end
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 20);
      end else begin
         burst_left--;
      end
   endtask

   task automatic write_reg(input logic [scf_pkg::CSR_IDX_W-1:0] idx,
                            input logic [12:0] data);
      start <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      if (idx == scf_pkg::CSR_SPP) spp_reg = data[2:0];
      else width_reg = data;
   endtask

   task automatic fetch_pixel(input logic signed [15:0] col, input bit refresh);
      int n;
      int c;
      int rot;
      int addr;
      c   = clamp_column(col);
      n   = eff_spp();
      rot = $urandom_range(0, n - 1);
      for (int k = 0; k < n; k++) begin
         addr = c * n + (k + rot) % n;
         if (refresh || !row_written[addr])
            send_txn(make_req(scf_pkg::CMD_LOAD, addr[13:0], 8'($urandom_range(0, 255)),
                              16'($urandom_range(0, 65535))), 1'b0, '0);
      end
      send_txn(make_req(scf_pkg::CMD_FETCH, 14'($urandom_range(0, 16383)),
                        8'($urandom_range(0, 255)), col), 1'b0, '0);
   endtask

   always @(posedge clock) begin : pixel_check
      scf_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("unexpected pixel", rsp_payload, '0);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_payload.alpha !== want.alpha)
               report_mismatch("alpha", 32'(rsp_payload.alpha), 32'(want.alpha));
            if (rsp_payload.red !== want.red)
               report_mismatch("red", 32'(rsp_payload.red), 32'(want.red));
            if (rsp_payload.green !== want.green)
               report_mismatch("green", 32'(rsp_payload.green), 32'(want.green));
            if (rsp_payload.blue !== want.blue)
               report_mismatch("blue", 32'(rsp_payload.blue), 32'(want.blue));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1 ||
          (csr_valid && csr_ready === 1'b1))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      logic [2:0]         spp_plan   [PHASES];
      logic [12:0]        width_plan [PHASES];
      logic [12:0]        spp_word;
      logic signed [15:0] col;
      int                 target;
      int                 pick;
      int                 w;

      spp_plan   = '{3'd4, 3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd6, 3'd7, 3'd4, 3'd3};
      width_plan = '{13'd4096, 13'd4096, 13'd1, 13'd4095, 13'd0, 13'h1fff,
                     13'($urandom_range(3, 4096)), 13'd2, 13'd4097,
                     13'($urandom_range(1, 64))};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_steps[i]) begin
         case (directed_steps[i].kind)
            STEP_LOAD:
               send_txn(make_req(scf_pkg::CMD_LOAD, directed_steps[i].idx,
                                 directed_steps[i].data[7:0],
                                 16'($urandom_range(0, 65535))), 1'b0, '0);
            STEP_FETCH:
               send_txn(make_req(scf_pkg::CMD_FETCH, 14'($urandom_range(0, 16383)),
                                 8'($urandom_range(0, 255)), directed_steps[i].col),
                        directed_steps[i].typed, directed_steps[i].pix);
            STEP_SPP:   write_reg(scf_pkg::CSR_SPP, directed_steps[i].data);
            default:    write_reg(scf_pkg::CSR_WIDTH, directed_steps[i].data);
         endcase
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         spp_word      = 13'($urandom);
         spp_word[2:0] = spp_plan[ph];
         write_reg(scf_pkg::CSR_SPP, spp_word);
         write_reg(scf_pkg::CSR_WIDTH, width_plan[ph]);
         w      = eff_width();
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
               send_txn(make_req(scf_pkg::CMD_LOAD, 14'($urandom_range(0, 16383)),
                                 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535))),
                        1'b0, '0);
            end else if (pick < 72) begin
               case ($urandom_range(0, 9))
                  0: col = -16'sd1 - 16'($urandom_range(0, 32767));
                  1: col = 16'(w + $urandom_range(0, 32767 - w));
                  default: col = 16'($urandom_range(0, w - 1));
               endcase
               fetch_pixel(col, 1'b1);
            end else if (pick < 97) begin
               if ($urandom_range(0, 1) == 0) col = 16'($urandom_range(0, 65535));
               else col = 16'($urandom_range(0, w + 2));
               fetch_pixel(col, 1'b0);
            end else begin
               start <= 1'b0;
               do @(posedge clock); while (pending_pixels.size() != 0);
            end
         end
      end

      start <= 1'b0;
      do @(posedge clock); while (pending_pixels.size() != 0);
      repeat (16) @(posedge clock);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
